// ===== hw/rtl/u8td_pkg.sv =====
// Shared types and constants for the UTF-8 text detector.
// No dependencies; imported by every other file of the block.
package u8td_pkg;

  localparam logic [7:0] THRESHOLD_RESET = 8'd10;

  // Byte classification masks and patterns
  localparam logic [7:0] MASK_TOP   = 8'h80;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  localparam logic [8:0] COUNT_MAX = 9'd259;

  typedef enum logic [1:0] {
    LATCH_UNDECIDED = 2'd0,
    LATCH_ACCEPT    = 2'd1,
    LATCH_REJECT    = 2'd2
  } latch_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic load;
    logic is_utf8;
  } result_t;

endpackage

// ===== hw/rtl/u8td_core.sv =====
// Per-string scan state and the single-pass byte update of the detector.
// Depends on u8td_pkg.
module u8td_core
  import u8td_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  item_t      item,
  input  logic [7:0] threshold,
  output result_t    result
);

  logic [1:0] pend_r, pend_nxt;
  logic [2:0] seq_r, seq_nxt;
  logic [8:0] count_r, count_nxt;
  latch_t     latch_r, latch_nxt;
  logic [1:0] pend_dec;
  logic [8:0] count_sum;
  logic       verdict;

  assign pend_dec  = pend_r - 2'd1;
  assign count_sum = count_r + {6'd0, seq_r};

  always_comb begin
    pend_nxt  = pend_r;
    seq_nxt   = seq_r;
    count_nxt = count_r;
    latch_nxt = latch_r;
    if (latch_r == LATCH_UNDECIDED) begin
      if (pend_r != 2'd0) begin
        if ((item.text_byte & MASK_CONT) != PAT_CONT) begin
          latch_nxt = LATCH_REJECT;
        end else begin
          pend_nxt = pend_dec;
          if (pend_dec == 2'd0) begin
            count_nxt = count_sum;
            seq_nxt   = 3'd0;
            if (count_sum > {1'b0, threshold}) begin
              latch_nxt = LATCH_ACCEPT;
            end
          end
        end
      end else if ((item.text_byte & MASK_TOP) != 8'd0) begin
        if ((item.text_byte & MASK_LEAD2) == PAT_LEAD2) begin
          pend_nxt = 2'd1;
          seq_nxt  = 3'd2;
        end else if ((item.text_byte & MASK_LEAD3) == PAT_LEAD3) begin
          pend_nxt = 2'd2;
          seq_nxt  = 3'd3;
        end else if ((item.text_byte & MASK_LEAD4) == PAT_LEAD4) begin
          pend_nxt = 2'd3;
          seq_nxt  = 3'd4;
        end else begin
          latch_nxt = LATCH_REJECT;
        end
      end
    end
  end

  always_comb begin
    case (latch_nxt)
      LATCH_ACCEPT:    verdict = 1'b1;
      LATCH_REJECT:    verdict = 1'b0;
      LATCH_UNDECIDED: verdict = (pend_nxt == 2'd0) && (count_nxt != 9'd0);
      default:         verdict = 1'b0;
    endcase
  end

  assign result.load    = advance && item.last_byte;
  assign result.is_utf8 = verdict;

  // Clear everything after the last byte of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 2'd0;
      seq_r   <= 3'd0;
      count_r <= 9'd0;
      latch_r <= LATCH_UNDECIDED;
    end else if (advance) begin
      if (item.last_byte) begin
        pend_r  <= 2'd0;
        seq_r   <= 3'd0;
        count_r <= 9'd0;
        latch_r <= LATCH_UNDECIDED;
      end else begin
        pend_r  <= pend_nxt;
        seq_r   <= seq_nxt;
        count_r <= count_nxt;
        latch_r <= latch_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // The full length stays put while continuations count down, so it always
  // exceeds the number still expected
  a_seq_tracks_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd0) |-> (seq_r > {1'b0, pend_r}))
    else $error("sequence length out of step with pending continuations");

  a_seq_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd0) |-> (seq_r == 3'd0))
    else $error("sequence length left over with no sequence open");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("multibyte count beyond its bound");
`endif

endmodule

// ===== hw/rtl/u8td_out.sv =====
// Result register of the detector: holds one verdict until transferred.
// Depends on u8td_pkg.
module u8td_out
  import u8td_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  result_t result,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_is_utf8
);

  logic out_valid_r, out_valid_nxt;
  logic is_utf8_r;

  assign free = !out_valid_r || out_ready;

  always_comb begin
    if (result.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      is_utf8_r <= result.is_utf8;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_is_utf8 = is_utf8_r;

endmodule

// ===== hw/rtl/utf8_text_detector.sv =====
// Top level of the UTF-8 text detector: input register, threshold register,
// scan core and result register. Depends on u8td_pkg, u8td_core, u8td_out.
//
//  channel   ports                              direction  moves
//  in        in_valid/in_ready, in_text_byte,   input      one byte per transfer
//            in_last_byte
//  out       out_valid/out_ready, out_is_utf8   output     one verdict per string
//  cfg       cfg_we, cfg_wdata                  input      accept threshold write
//
// One byte per cycle unless a last byte waits on a full result register: a byte
// is held in the input register and the core's single-pass update moves it on.
// A verdict appears on out_valid at the edge that moves its last byte out of
// the input register; the result register frees in the cycle it is transferred.
// Input stalls only while a last byte waits on a full result register.
// Reset (rst_n low, synchronous) empties both registers, clears the scan
// state and sets the threshold to 10.
module utf8_text_detector
  import u8td_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_utf8,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic       in_valid_r, in_valid_nxt;
  item_t      item_r;
  logic [7:0] threshold_r;
  logic       out_free;
  logic       advance;
  logic       in_xfer;
  result_t    result;

  // Advance the held byte unless it ends a string and the verdict slot is full
  assign advance  = in_valid_r && (!item_r.last_byte || out_free);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Hold payload until the next transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.text_byte <= in_text_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_wdata;
    end
  end

  u8td_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item_r),
    .threshold (threshold_r),
    .result    (result)
  );

  u8td_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .result      (result),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_utf8 (out_is_utf8)
  );

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.last_byte) |=> out_valid)
    else $error("last byte moved on without a verdict");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && item_r.last_byte && out_valid && !out_ready))
    else $error("input stalled without a blocked verdict");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for utf8_text_detector: directed and random strings
// against a built-in verdict predictor, with random idling on both channels.
// Depends on u8td_pkg and the utf8_text_detector RTL.
module tb_top
  import u8td_pkg::*;
();

  localparam int IDLE_PCT     = 8;   // chance per cycle that a side idles
  localparam int HOLD_CYCLES  = 60;  // long receiver hold-off for the pressure test
  localparam int DRAIN_CYCLES = 4;   // input register + core + result register, with margin

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_text_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_is_utf8;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // Verdict predictor state; mirrors the block's scan registers
  logic [1:0] scan_pend;
  logic [2:0] scan_len;
  logic [8:0] scan_count;
  latch_t     scan_latch;
  logic [7:0] model_threshold;

  logic       verdict_q[$];   // verdicts owed by the block, oldest first
  logic [7:0] str_buf[$];     // string under construction

  // Run bookkeeping
  int  err_count;
  int  bytes_sent;
  int  strings_judged;
  int  strings_utf8;
  int  thresholds_set;
  bit  steady;                // suppress random idling on both sides
  bit  hold_req;              // ask the receiver for a long hold-off
  int  hold_req_len;

  utf8_text_detector u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_utf8  (out_is_utf8),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan_pend  = '0;
    scan_len   = '0;
    scan_count = '0;
    scan_latch = LATCH_UNDECIDED;
  endfunction

  // Advance the scan by one transferred byte; on a last byte, queue the
  // verdict and return the scan to its reset state.
  function automatic void judge_byte(logic [7:0] b, logic last);
    logic verdict;
    // A latched accept or reject freezes the scan until the string ends
    if (scan_latch == LATCH_UNDECIDED) begin
      if (scan_pend != 0) begin
        if ((b & MASK_CONT) != PAT_CONT) begin
          scan_latch = LATCH_REJECT;
        end else begin
          scan_pend = scan_pend - 2'd1;
          if (scan_pend == 0) begin
            // Sequence complete: credit its full length, then test early accept
            scan_count = scan_count + 9'(scan_len);
            scan_len   = '0;
            if (scan_count > {1'b0, model_threshold}) scan_latch = LATCH_ACCEPT;
          end
        end
      end else if ((b & MASK_TOP) != 0) begin
        if ((b & MASK_LEAD2) == PAT_LEAD2) begin
          scan_pend = 2'd1;
          scan_len  = 3'd2;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
          scan_pend = 2'd2;
          scan_len  = 3'd3;
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
          scan_pend = 2'd3;
          scan_len  = 3'd4;
        end else begin
          // Stray byte where a lead or ASCII belongs
          scan_latch = LATCH_REJECT;
        end
      end
    end
    if (last) begin
      case (scan_latch)
        LATCH_ACCEPT: verdict = 1'b1;
        LATCH_REJECT: verdict = 1'b0;
        // Undecided: a truncated tail fails, else any completed sequence passes
        default:      verdict = (scan_pend == 0) && (scan_count != 0);
      endcase
      verdict_q.push_back(verdict);
      strings_judged++;
      if (verdict) strings_utf8++;
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Compare every verdict transfer with the oldest owed verdict
  always @(posedge clk) begin : check_verdicts
    logic want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %b with none owed", out_is_utf8));
      end else begin
        want = verdict_q.pop_front();
        if (out_is_utf8 !== want)
          report_mismatch($sformatf("is_utf8 %b, want %b (string %0d)",
                                    out_is_utf8, want,
                                    strings_judged - verdict_q.size()));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, quiet while steady, and a long hold on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        // Take the request and count the hold-off here, in cycles
        hold_left = hold_req_len - 1;
        hold_req  = 1'b0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until transferred. Called at a rising edge;
  // returns at the edge of the transfer with in_valid still high, so the next
  // call can keep it high without a dip.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    judge_byte(b, last);
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < str_buf.size(); i++) push_byte(str_buf[i], i == str_buf.size() - 1);
  endtask

  // Drop valid and wait until every owed verdict is back, then let the
  // pipeline empty before anything touches the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we          <= 1'b0;
    model_threshold  = value;
    thresholds_set++;
  endtask

  // ---------------------------------------------------------------------------
  // String generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] cont_byte();
    return PAT_CONT | 8'($urandom_range(63));
  endfunction

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      2:       return PAT_LEAD2 | 8'($urandom_range(31));
      3:       return PAT_LEAD3 | 8'($urandom_range(15));
      default: return PAT_LEAD4 | 8'($urandom_range(7));
    endcase
  endfunction

  // Fill str_buf with n_chars characters. Most are well-formed ASCII or
  // multibyte; noise_pct of them are broken, and with the same chance the
  // string ends inside a sequence.
  task automatic build_string(input int n_chars, input int noise_pct);
    int         i, r, len, cut;
    logic [7:0] b;
    str_buf.delete();
    for (i = 0; i < n_chars; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        if ($urandom_range(1) == 0) begin
          // Stray: orphan continuation or one of the never-valid high bytes
          if ($urandom_range(1) == 0) str_buf.push_back(cont_byte());
          else                        str_buf.push_back(8'hF8 | 8'($urandom_range(7)));
        end else begin
          // Lead, some continuations, then a byte that is not one
          len = $urandom_range(2, 4);
          str_buf.push_back(lead_byte(len));
          cut = $urandom_range(0, len - 2);
          repeat (cut) str_buf.push_back(cont_byte());
          do b = 8'($urandom); while ((b & MASK_CONT) == PAT_CONT);
          str_buf.push_back(b);
        end
      end else begin
        r = $urandom_range(99);
        if (r < 35) begin
          str_buf.push_back(8'($urandom_range(127)));
        end else begin
          len = (r < 55) ? 2 : (r < 75) ? 3 : 4;
          str_buf.push_back(lead_byte(len));
          repeat (len - 1) str_buf.push_back(cont_byte());
        end
      end
    end
    // Truncated tail
    if ($urandom_range(99) < noise_pct) begin
      len = $urandom_range(2, 4);
      str_buf.push_back(lead_byte(len));
      cut = $urandom_range(0, len - 2);
      repeat (cut) str_buf.push_back(cont_byte());
    end
    if (str_buf.size() == 0) str_buf.push_back(8'($urandom_range(127)));
  endtask

  task automatic run_random(input int byte_budget, input int max_chars, input int noise_pct);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_budget) begin
      build_string($urandom_range(1, max_chars), noise_pct);
      send_string();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked strings at the reset threshold: one per byte class and
  // special case, with the byte extremes 0x00, 0x7F, 0x80 and 0xFF.
  task automatic test_directed();
    str_buf = '{8'h00, 8'h7F};                 send_string();  // plain ASCII
    str_buf = '{8'hC3, 8'hA9};                 send_string();  // two-byte
    str_buf = '{8'hE2, 8'h82, 8'hAC};          send_string();  // three-byte
    str_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};   send_string();  // four-byte
    str_buf = '{8'h80};                        send_string();  // stray continuation
    str_buf = '{8'hFF, 8'h41};                 send_string();  // stray high byte, latched
    str_buf = '{8'hC3, 8'h41};                 send_string();  // bad continuation
    str_buf = '{8'hE2, 8'h82};                 send_string();  // truncated at the end
  endtask

  // Random strings before any register write, so the reset threshold decides
  task automatic test_reset_threshold();
    run_random(250, 10, 12);
  endtask

  // Threshold 0: the first completed sequence accepts and the stray after it
  // is ignored. Run this phase with no idling on either side.
  task automatic test_zero_threshold();
    write_threshold(8'd0);
    str_buf = '{8'hC3, 8'hA9, 8'hFF, 8'h41};
    send_string();
    steady = 1'b1;
    run_random(200, 6, 15);
    steady = 1'b0;
  endtask

  // Threshold 255: one long well-formed string that crosses it, then short ones
  task automatic test_max_threshold();
    write_threshold(8'd255);
    build_string(180, 0);
    send_string();
    run_random(80, 8, 15);
  endtask

  task automatic test_random_thresholds();
    repeat (3) begin
      write_threshold(8'($urandom_range(1, 24)));
      run_random(100, 12, 12);
    end
  endtask

  // Hold the receiver off while short strings keep coming, so verdicts back
  // up into the block and it stalls its input.
  task automatic test_backpressure();
    write_threshold(8'd1);
    hold_req_len = HOLD_CYCLES;
    hold_req     = 1'b1;
    steady       = 1'b1;
    repeat (30) begin
      build_string($urandom_range(1, 2), 10);
      send_string();
    end
    steady = 1'b0;
    run_random(80, 6, 12);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_text_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    err_count      = 0;
    bytes_sent     = 0;
    strings_judged = 0;
    strings_utf8   = 0;
    thresholds_set = 0;
    steady         = 1'b0;
    hold_req       = 1'b0;
    hold_req_len   = 0;
    model_threshold = THRESHOLD_RESET;
    clear_scan();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_reset_threshold();
    test_zero_threshold();
    test_max_threshold();
    test_random_thresholds();
    test_backpressure();
    settle();

    $display("tb_top: %0d bytes in %0d strings, %0d judged UTF-8", bytes_sent,
             strings_judged, strings_utf8);
    $display("tb_top: reset threshold plus %0d written (0 and 255 among them), one %0d-cycle hold",
             thresholds_set, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_top: watchdog expired with %0d verdicts owed", verdict_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/u8td_pkg.sv
hw/rtl/u8td_core.sv
hw/rtl/u8td_out.sv
hw/rtl/utf8_text_detector.sv
tb/sv/tb_top.sv
